// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL of the ARP cache table (used by arp_cache_table).
// No dependencies; files take it in by include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/act_pkg.sv -----
// Package for the ARP cache table: field widths, operation codes and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package act_pkg;

  // Field widths.
  localparam int MAC_BYTES = 6;
  localparam int OP_W      = 2;
  localparam int IP_W      = 32;
  localparam int MAC_W     = MAC_BYTES * 8;
  localparam int TIME_W    = 32;
  localparam int TMO_W     = 16;
  localparam int CNT_W     = 5;
  localparam int RAM_W     = IP_W + MAC_W + TIME_W;

  // Default table size and register reset.
  localparam int                ENTRIES_DEF = 16;
  localparam logic [TMO_W-1:0]  TIMEOUT_RST = 16'd15;
  localparam logic [CNT_W-1:0]  CNT_MAX     = 5'd31;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the request, clear the result, rewind the index
    logic idx_inc;    // advance the slot index
    logic rd_issue;   // read the slot at the current index
    logic ins_write;  // write the request into the slot at the current index
    logic publish;    // move the finished result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_last;   // the index points at the last slot
    logic slot_free;  // the slot at the index is not valid
    logic out_full;   // the output register still holds an untaken result
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/act_ifs.sv -----
// Channel interfaces of the ARP cache table: request, response and the
// timeout configuration write. Depends on act_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface act_req_if import act_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [IP_W-1:0]   ip_address;
  logic [MAC_W-1:0]  mac_address;

  modport source (output valid, operation, ip_address, mac_address, input ready);
  modport sink   (input valid, operation, ip_address, mac_address, output ready);
endinterface

interface act_rsp_if import act_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [MAC_W-1:0]  found_mac;
  logic              stored;
  logic [CNT_W-1:0]  expired_count;

  modport source (output valid, hit, found_mac, stored, expired_count, input ready);
  modport sink   (input valid, hit, found_mac, stored, expired_count, output ready);
endinterface

interface act_cfg_if import act_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TMO_W-1:0]  timeout_seconds;

  modport source (output valid, timeout_seconds, input ready);
  modport sink   (input valid, timeout_seconds, output ready);
endinterface

`default_nettype wire

// ----- hdl/act_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module act_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/act_ctrl.sv -----
// Controller of the ARP cache table: sequences the slot scan for each request.
// Depends on act_pkg.
`timescale 1ns / 1ps
`default_nettype none

module act_ctrl import act_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  input  sts_t            sts,
  output cmd_t            cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_INSERT = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_op) inside
            OP_LOOKUP, OP_TICK: state_next = S_SCAN;
            OP_INSERT:          state_next = S_INSERT;
            default:            state_next = S_DONE;
          endcase
        end
      end
      // One slot read per cycle; each read is checked in the cycle after it.
      S_SCAN: begin
        cmd.rd_issue = 1'b1;
        if (sts.idx_last) begin
          state_next = S_DRAIN;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      // The last slot read is checked in this cycle.
      S_DRAIN: begin
        state_next = S_DONE;
      end
      // Walk the valid marks up to the first free slot, or to the last slot if none is free.
      S_INSERT: begin
        if (sts.slot_free) begin
          cmd.ins_write = 1'b1;
          state_next    = S_DONE;
        end else if (sts.idx_last) begin
          state_next = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DONE: begin
        if (!sts.out_full) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/act_dpath.sv -----
// Datapath of the ARP cache table: slot RAM, valid marks, seconds counter,
// timeout register, result accumulators and output register.
// Depends on act_pkg and act_ram.
`timescale 1ns / 1ps
`default_nettype none

module act_dpath import act_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [OP_W-1:0]  in_op,
  input  logic [IP_W-1:0]  in_ip,
  input  logic [MAC_W-1:0] in_mac,
  input  logic             cfg_we,
  input  logic [TMO_W-1:0] cfg_timeout,
  input  logic             rsp_ready,
  output logic             rsp_valid,
  output logic             rsp_hit,
  output logic [MAC_W-1:0] rsp_found_mac,
  output logic             rsp_stored,
  output logic [CNT_W-1:0] rsp_expired_count
);

  // Latched request.
  logic [OP_W-1:0]   op;
  logic [IP_W-1:0]   ip;
  logic [MAC_W-1:0]  mac;

  // Table state and configuration.
  logic [ENTRIES-1:0] valid;
  logic [TIME_W-1:0]  now;
  logic [TMO_W-1:0]   timeout;

  // Scan index and the delayed check that follows each read.
  logic [IDX_W-1:0]   idx;
  logic               chk;
  logic [IDX_W-1:0]   chk_idx;

  // Result accumulators.
  logic               acc_hit;
  logic [MAC_W-1:0]   acc_mac;
  logic               acc_stored;
  logic [CNT_W-1:0]   acc_cnt;

  // Slot RAM read data split into its fields.
  logic [RAM_W-1:0]   rd_data;
  logic [IP_W-1:0]    rd_ip;
  logic [MAC_W-1:0]   rd_mac;
  logic [TIME_W-1:0]  rd_time;
  logic [TIME_W-1:0]  age;
  logic               chk_valid;
  logic               ip_match;
  logic               expired;

  assign rd_ip   = rd_data[RAM_W-1 -: IP_W];
  assign rd_mac  = rd_data[TIME_W +: MAC_W];
  assign rd_time = rd_data[TIME_W-1:0];

  act_ram #(
    .WIDTH (RAM_W),
    .DEPTH (ENTRIES)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.ins_write),
    .waddr (idx),
    .wdata ({ip, mac, now}),
    .re    (cmd.rd_issue),
    .raddr (idx),
    .rdata (rd_data)
  );

  // Check of the slot whose read data has just arrived.
  assign chk_valid = valid[chk_idx];
  assign ip_match  = chk_valid && (rd_ip == ip);
  assign age       = now - rd_time;
  assign expired   = chk_valid && (age > {{(TIME_W-TMO_W){1'b0}}, timeout});

  // Status toward the controller.
  assign sts.idx_last  = (idx == IDX_W'(ENTRIES - 1));
  assign sts.slot_free = !valid[idx];
  assign sts.out_full  = rsp_valid && !rsp_ready;

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_op;
      ip  <= in_ip;
      mac <= in_mac;
    end
  end

  // Timeout register, written by the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RST;
    end else if (cfg_we) begin
      timeout <= cfg_timeout;
    end
  end

  // Seconds counter; a tick advances it before its scan starts.
  always_ff @(posedge clk) begin
    if (rst) begin
      now <= '0;
    end else if (cmd.load && in_op == OP_TICK) begin
      now <= now + TIME_W'(1);
    end
  end

  // Scan index and the check strobe trailing the RAM read.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      chk <= 1'b0;
    end else begin
      chk <= cmd.rd_issue;
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= idx;
  end

  // Valid marks: set by an insert, cleared by an expiring tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.ins_write) begin
      valid[idx] <= 1'b1;
    end else if (chk && op == OP_TICK && expired) begin
      valid[chk_idx] <= 1'b0;
    end
  end

  // Result accumulators; the ascending scan leaves the highest matching slot.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_hit    <= 1'b0;
      acc_mac    <= '0;
      acc_stored <= 1'b0;
      acc_cnt    <= '0;
    end else begin
      if (cmd.ins_write) begin
        acc_stored <= 1'b1;
      end
      if (chk && op == OP_LOOKUP && ip_match) begin
        acc_hit <= 1'b1;
        acc_mac <= rd_mac;
      end
      if (chk && op == OP_TICK && expired && acc_cnt != CNT_MAX) begin
        acc_cnt <= acc_cnt + CNT_W'(1);
      end
    end
  end

  // Output register holding one response transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.publish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      rsp_hit           <= acc_hit;
      rsp_found_mac     <= acc_mac;
      rsp_stored        <= acc_stored;
      rsp_expired_count <= acc_cnt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/arp_cache_table.sv -----
// ARP cache table: one request transaction at a time, one response each.
// Lookup and tick read one slot RAM entry per cycle, check the last read, then
// publish; insert walks to the first free slot and writes it, or stops at the
// last slot; other codes publish at once. Publishing waits while the output
// is full, and a new request is taken as soon as the result is registered.
// Synchronous reset clears valid marks and seconds, timeout to 15.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module arp_cache_table import act_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input logic       clk,
  input logic       rst,
  act_req_if.sink   req,
  act_rsp_if.source rsp,
  act_cfg_if.sink   cfg
);

  cmd_t cmd;
  sts_t sts;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  act_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_op    (req.operation),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  act_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (req.operation),
    .in_ip             (req.ip_address),
    .in_mac            (req.mac_address),
    .cfg_we            (cfg.valid & cfg.ready),
    .cfg_timeout       (cfg.timeout_seconds),
    .rsp_ready         (rsp.ready),
    .rsp_valid         (rsp.valid),
    .rsp_hit           (rsp.hit),
    .rsp_found_mac     (rsp.found_mac),
    .rsp_stored        (rsp.stored),
    .rsp_expired_count (rsp.expired_count)
  );

  // An accepted request keeps the block busy for at least the next cycle.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready)
  // A result is never published over one that has not been taken.
  `ASSERT_IMPLIES(a_publish_free, clk, rst, cmd.publish, !sts.out_full)
  // An insert only ever writes a free slot.
  `ASSERT_IMPLIES(a_insert_free, clk, rst, cmd.ins_write, sts.slot_free)

endmodule

`default_nettype wire
